@@ sv/ctbi_pkg.sv @@
// ----------------------------------------------------------------------------
// ctbi_pkg: shared definitions for the coordinate to bin index block
// Widths, register codes, reset values and the per-axis case code.
// ----------------------------------------------------------------------------
package ctbi_pkg;

  localparam int COORD_BITS_DEF  = 21;
  localparam int BIN_BITS_DEF    = 11;
  localparam int NUM_AXES        = 3;
  localparam int FRAC_PRODUCT    = 24;
  localparam int CFG_DATA_BITS   = 63;
  localparam int CFG_INDEX_BITS  = 3;
  localparam int CNT_REG_BITS    = 30;
  localparam int OFF_REG_BITS    = 33;
  localparam int STRIDE_REG_BITS = 22;
  localparam int INDEX_BITS      = 33;
  localparam int FIELD_PAD_BITS  = 192;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_BOX_LOW      = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BOX_HIGH     = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INV_SIZE     = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INNER_COUNTS = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GHOST_OFFS   = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_STRIDES = 3'd5;

  localparam logic [CNT_REG_BITS-1:0]    CNT_RESET    = 30'd1049601;
  localparam logic [STRIDE_REG_BITS-1:0] STRIDE_RESET = 22'd2049;

  typedef enum logic [1:0] {
    CASE_INSIDE = 2'd0,
    CASE_ABOVE  = 2'd1,
    CASE_BELOW  = 2'd2
  } axis_case_t;

endpackage

@@ sv/ctbi_cfg.sv @@
// ----------------------------------------------------------------------------
// ctbi_cfg: configuration registers
// Holds the six registers, splits them into per-axis fields and keeps the
// derived grid limits and the xy plane size in registers.
// ----------------------------------------------------------------------------
module ctbi_cfg import ctbi_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int BIN_BITS   = BIN_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0]        cfg_index,
  input  logic [CFG_DATA_BITS-1:0]         cfg_data,
  output logic signed [COORD_BITS-1:0]     box_lo   [NUM_AXES],
  output logic signed [COORD_BITS-1:0]     box_hi   [NUM_AXES],
  output logic [COORD_BITS-1:0]            inv_size [NUM_AXES],
  output logic [BIN_BITS-2:0]              cnt      [NUM_AXES],
  output logic signed [BIN_BITS-1:0]       ghost    [NUM_AXES],
  output logic [BIN_BITS-1:0]              upper    [NUM_AXES],
  output logic [BIN_BITS-1:0]              nx,
  output logic [2*BIN_BITS-1:0]            nxy
);

  logic [CFG_DATA_BITS-1:0]   box_low_xyz;
  logic [CFG_DATA_BITS-1:0]   box_high_xyz;
  logic [CFG_DATA_BITS-1:0]   inverse_bin_size_xyz;
  logic [CNT_REG_BITS-1:0]    inner_bin_counts;
  logic [OFF_REG_BITS-1:0]    ghost_bin_offsets;
  logic [STRIDE_REG_BITS-1:0] grid_strides;

  logic [FIELD_PAD_BITS-1:0]  low_pad;
  logic [FIELD_PAD_BITS-1:0]  high_pad;
  logic [FIELD_PAD_BITS-1:0]  inv_pad;
  logic [FIELD_PAD_BITS-1:0]  cnt_pad;
  logic [FIELD_PAD_BITS-1:0]  ghost_pad;
  logic [FIELD_PAD_BITS-1:0]  stride_pad;
  logic [BIN_BITS-1:0]        ny;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_low_xyz          <= '0;
      box_high_xyz         <= '0;
      inverse_bin_size_xyz <= '0;
      inner_bin_counts     <= CNT_RESET;
      ghost_bin_offsets    <= '0;
      grid_strides         <= STRIDE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BOX_LOW:      box_low_xyz          <= cfg_data;
        REG_BOX_HIGH:     box_high_xyz         <= cfg_data;
        REG_INV_SIZE:     inverse_bin_size_xyz <= cfg_data;
        REG_INNER_COUNTS: inner_bin_counts     <= cfg_data[CNT_REG_BITS-1:0];
        REG_GHOST_OFFS:   ghost_bin_offsets    <= cfg_data[OFF_REG_BITS-1:0];
        REG_GRID_STRIDES: grid_strides         <= cfg_data[STRIDE_REG_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Fields that run past the top of a register read as zero.
  assign low_pad    = FIELD_PAD_BITS'(box_low_xyz);
  assign high_pad   = FIELD_PAD_BITS'(box_high_xyz);
  assign inv_pad    = FIELD_PAD_BITS'(inverse_bin_size_xyz);
  assign cnt_pad    = FIELD_PAD_BITS'(inner_bin_counts);
  assign ghost_pad  = FIELD_PAD_BITS'(ghost_bin_offsets);
  assign stride_pad = FIELD_PAD_BITS'(grid_strides);

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      box_lo[a]   = $signed(low_pad[a*COORD_BITS +: COORD_BITS]);
      box_hi[a]   = $signed(high_pad[a*COORD_BITS +: COORD_BITS]);
      inv_size[a] = inv_pad[a*COORD_BITS +: COORD_BITS];
      cnt[a]      = cnt_pad[a*(BIN_BITS-1) +: BIN_BITS-1];
      ghost[a]    = $signed(ghost_pad[a*BIN_BITS +: BIN_BITS]);
    end
  end

  assign nx = stride_pad[0 +: BIN_BITS];
  assign ny = stride_pad[BIN_BITS +: BIN_BITS];

  always_ff @(posedge clk) begin
    upper[0] <= (nx == '0) ? '0 : nx - 1'b1;
    upper[1] <= (ny == '0) ? '0 : ny - 1'b1;
    upper[2] <= '1;
    nxy      <= (2*BIN_BITS)'(nx) * (2*BIN_BITS)'(ny);
  end

endmodule

@@ sv/ctbi_front.sv @@
// ----------------------------------------------------------------------------
// ctbi_front: position intake and classification
// Compares each coordinate with the box, picks the case per axis and the
// distance magnitude to be scaled, and registers the classified word.
// ----------------------------------------------------------------------------
module ctbi_front import ctbi_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [COORD_BITS-1:0]           pos_x,
  input  logic signed [COORD_BITS-1:0]           pos_y,
  input  logic signed [COORD_BITS-1:0]           pos_z,
  input  logic signed [COORD_BITS-1:0]           box_lo [NUM_AXES],
  input  logic signed [COORD_BITS-1:0]           box_hi [NUM_AXES],
  output logic                                   fr_valid,
  input  logic                                   fr_ready,
  output logic [NUM_AXES*(COORD_BITS+2)-1:0]     fr_word
);

  localparam int SLOT_W = COORD_BITS + 2;

  logic signed [COORD_BITS-1:0]  pos      [NUM_AXES];
  logic signed [COORD_BITS:0]    d_hi     [NUM_AXES];
  logic signed [COORD_BITS:0]    d_lo     [NUM_AXES];
  logic signed [COORD_BITS:0]    d_lo_neg [NUM_AXES];
  axis_case_t                    cls      [NUM_AXES];
  logic [COORD_BITS-1:0]         mag      [NUM_AXES];
  logic [NUM_AXES*SLOT_W-1:0]    fr_word_next;

  assign pos[0] = pos_x;
  assign pos[1] = pos_y;
  assign pos[2] = pos_z;

  always_comb begin
    fr_word_next = '0;
    for (int a = 0; a < NUM_AXES; a++) begin
      d_hi[a]     = $signed({pos[a][COORD_BITS-1], pos[a]})
                  - $signed({box_hi[a][COORD_BITS-1], box_hi[a]});
      d_lo[a]     = $signed({pos[a][COORD_BITS-1], pos[a]})
                  - $signed({box_lo[a][COORD_BITS-1], box_lo[a]});
      d_lo_neg[a] = -d_lo[a];
      // The upper test wins, so a box with its corners swapped still
      // resolves the same way as the scalar formula.
      if (!d_hi[a][COORD_BITS]) begin
        cls[a] = CASE_ABOVE;
        mag[a] = d_hi[a][COORD_BITS-1:0];
      end else if (!d_lo[a][COORD_BITS]) begin
        cls[a] = CASE_INSIDE;
        mag[a] = d_lo[a][COORD_BITS-1:0];
      end else begin
        cls[a] = CASE_BELOW;
        mag[a] = d_lo_neg[a][COORD_BITS-1:0];
      end
      fr_word_next[a*SLOT_W +: SLOT_W] = {cls[a], mag[a]};
    end
  end

  assign in_ready = !fr_valid || fr_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else if (in_ready) begin
      fr_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      fr_word <= fr_word_next;
    end
  end

endmodule

@@ sv/ctbi_queue.sv @@
// ----------------------------------------------------------------------------
// ctbi_queue: small word queue between intake and compute
// A short first-in first-out buffer with valid and ready on both sides.
// ----------------------------------------------------------------------------
module ctbi_queue import ctbi_pkg::*; #(
  parameter int WIDTH = 2*COORD_BITS_DEF,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_word,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_word
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign wr_ready = (count != CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_word  = mem[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_word;
    end
  end

endmodule

@@ sv/ctbi_back.sv @@
// ----------------------------------------------------------------------------
// ctbi_back: bin computation pipeline
// Five stages: scale by the inverse bin size, apply the per-axis case,
// offset and clamp into the grid, form the plane and row products, then sum.
// ----------------------------------------------------------------------------
module ctbi_back import ctbi_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int BIN_BITS   = BIN_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   bk_valid,
  output logic                                   bk_ready,
  input  logic [NUM_AXES*(COORD_BITS+2)-1:0]     bk_word,
  input  logic [COORD_BITS-1:0]                  inv_size [NUM_AXES],
  input  logic [BIN_BITS-2:0]                    cnt      [NUM_AXES],
  input  logic signed [BIN_BITS-1:0]             ghost    [NUM_AXES],
  input  logic [BIN_BITS-1:0]                    upper    [NUM_AXES],
  input  logic [BIN_BITS-1:0]                    nx,
  input  logic [2*BIN_BITS-1:0]                  nxy,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [INDEX_BITS-1:0]                  bin_index,
  output logic [BIN_BITS-1:0]                    cell_x,
  output logic [BIN_BITS-1:0]                    cell_y,
  output logic [BIN_BITS-1:0]                    cell_z,
  output logic                                   out_of_grid
);

  localparam int SLOT_W = COORD_BITS + 2;
  localparam int PROD_W = (2*COORD_BITS > FRAC_PRODUCT) ? 2*COORD_BITS : FRAC_PRODUCT + 1;
  localparam int Q_W    = PROD_W - FRAC_PRODUCT;
  localparam int B_W    = Q_W + BIN_BITS + 2;
  localparam int PZ_W   = 3*BIN_BITS;
  localparam int PY_W   = 2*BIN_BITS;
  localparam int SUM_W  = (PZ_W + 2 > INDEX_BITS) ? PZ_W + 2 : INDEX_BITS;
  localparam int NSTG   = 5;

  logic [NSTG-1:0]          vld;
  logic [NSTG-1:0]          stg_rdy;

  // Stage 0 inputs and stage 1 registers.
  axis_case_t               cs0   [NUM_AXES];
  logic [COORD_BITS-1:0]    mag0  [NUM_AXES];
  axis_case_t               cs1   [NUM_AXES];
  logic [PROD_W-1:0]        prod1 [NUM_AXES];

  // Stage 2 registers.
  logic signed [B_W-1:0]    qs    [NUM_AXES];
  logic signed [B_W-1:0]    cnt_s [NUM_AXES];
  logic signed [B_W-1:0]    b_next[NUM_AXES];
  logic signed [B_W-1:0]    b2    [NUM_AXES];

  // Stage 3 registers.
  logic signed [B_W-1:0]    off      [NUM_AXES];
  logic [BIN_BITS-1:0]      cell_nxt [NUM_AXES];
  logic [NUM_AXES-1:0]      clip;
  logic [BIN_BITS-1:0]      cell3    [NUM_AXES];
  logic                     flag3;

  // Stage 4 registers.
  logic [PZ_W-1:0]          pz4;
  logic [PY_W-1:0]          py4;
  logic [BIN_BITS-1:0]      cx4;
  logic [BIN_BITS-1:0]      cy4;
  logic [BIN_BITS-1:0]      cz4;
  logic                     flag4;
  logic [SUM_W-1:0]         sum;

  // A stage takes a new word when it is empty or its word moves on.
  always_comb begin
    stg_rdy[NSTG-1] = !vld[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      stg_rdy[k] = !vld[k] || stg_rdy[k+1];
    end
  end

  assign bk_ready  = stg_rdy[0];
  assign out_valid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (stg_rdy[0]) begin
        vld[0] <= bk_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (stg_rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Scale the distance by the inverse bin size.
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      cs0[a]  = axis_case_t'(bk_word[a*SLOT_W + COORD_BITS +: 2]);
      mag0[a] = bk_word[a*SLOT_W +: COORD_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (stg_rdy[0]) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        cs1[a]   <= cs0[a];
        prod1[a] <= PROD_W'(mag0[a]) * PROD_W'(inv_size[a]);
      end
    end
  end

  // Apply the case: above adds the inner count, inside clamps to count - 1,
  // below gives -q - 1, which is the bitwise complement of q.
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      qs[a]    = $signed(B_W'(prod1[a][PROD_W-1:FRAC_PRODUCT]));
      cnt_s[a] = $signed(B_W'(cnt[a]));
      unique case (cs1[a])
        CASE_ABOVE:  b_next[a] = qs[a] + cnt_s[a];
        CASE_INSIDE: b_next[a] = (qs[a] > cnt_s[a] - $signed(B_W'(1)))
                               ? cnt_s[a] - $signed(B_W'(1)) : qs[a];
        CASE_BELOW:  b_next[a] = ~qs[a];
        default:     b_next[a] = qs[a];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (stg_rdy[1]) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        b2[a] <= b_next[a];
      end
    end
  end

  // Offset by the lowest ghost bin and clamp into the grid.
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      off[a] = b2[a] - $signed({{(B_W-BIN_BITS){ghost[a][BIN_BITS-1]}}, ghost[a]});
      if (off[a] < 0) begin
        cell_nxt[a] = '0;
        clip[a]     = 1'b1;
      end else if (off[a] > $signed(B_W'(upper[a]))) begin
        cell_nxt[a] = upper[a];
        clip[a]     = 1'b1;
      end else begin
        cell_nxt[a] = off[a][BIN_BITS-1:0];
        clip[a]     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stg_rdy[2]) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        cell3[a] <= cell_nxt[a];
      end
      flag3 <= |clip;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_rdy[3]) begin
      pz4   <= PZ_W'(cell3[2]) * PZ_W'(nxy);
      py4   <= PY_W'(cell3[1]) * PY_W'(nx);
      cx4   <= cell3[0];
      cy4   <= cell3[1];
      cz4   <= cell3[2];
      flag4 <= flag3;
    end
  end

  assign sum = SUM_W'(pz4) + SUM_W'(py4) + SUM_W'(cx4);

  always_ff @(posedge clk) begin
    if (stg_rdy[4]) begin
      bin_index   <= sum[INDEX_BITS-1:0];
      cell_x      <= cx4;
      cell_y      <= cy4;
      cell_z      <= cz4;
      out_of_grid <= flag4;
    end
  end

endmodule

@@ sv/coordinate_to_bin_index.sv @@
// ----------------------------------------------------------------------------
// coordinate_to_bin_index: 3D position to cell-list bin
// Maps a fixed-point position to clamped per-axis bin offsets and a linear
// bin index, with an intake stage, a short queue and a compute pipeline.
//
//   channel  direction  handshake               payload
//   in       input      in_valid / in_ready     pos_x, pos_y, pos_z
//   out      output     out_valid / out_ready   bin_index, cell_x/y/z, out_of_grid
//   cfg      input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One word per clock cycle is accepted and delivered when neither side stalls.
// After the edge that accepts it into the intake register, a word enters the
// queue and then passes through the five compute stages to the output.
// Reset clears all valid flags and loads the configuration reset values.
// Each side stalls on its own; the queue and the pipeline registers absorb words
// while the output is held. Configuration must be written only while the block is
// idle (not enforced by the block); grid limits and plane size are registered.
// ----------------------------------------------------------------------------
module coordinate_to_bin_index import ctbi_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int BIN_BITS   = BIN_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_BITS-1:0]  pos_x,
  input  logic signed [COORD_BITS-1:0]  pos_y,
  input  logic signed [COORD_BITS-1:0]  pos_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [INDEX_BITS-1:0]         bin_index,
  output logic [BIN_BITS-1:0]           cell_x,
  output logic [BIN_BITS-1:0]           cell_y,
  output logic [BIN_BITS-1:0]           cell_z,
  output logic                          out_of_grid,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data
);

  localparam int WORD_W = NUM_AXES * (COORD_BITS + 2);

  logic signed [COORD_BITS-1:0]  box_lo   [NUM_AXES];
  logic signed [COORD_BITS-1:0]  box_hi   [NUM_AXES];
  logic [COORD_BITS-1:0]         inv_size [NUM_AXES];
  logic [BIN_BITS-2:0]           cnt      [NUM_AXES];
  logic signed [BIN_BITS-1:0]    ghost    [NUM_AXES];
  logic [BIN_BITS-1:0]           upper    [NUM_AXES];
  logic [BIN_BITS-1:0]           nx;
  logic [2*BIN_BITS-1:0]         nxy;

  logic                          fr_valid;
  logic                          fr_ready;
  logic [WORD_W-1:0]             fr_word;
  logic                          bk_valid;
  logic                          bk_ready;
  logic [WORD_W-1:0]             bk_word;

  ctbi_cfg #(
    .COORD_BITS (COORD_BITS),
    .BIN_BITS   (BIN_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .box_lo    (box_lo),
    .box_hi    (box_hi),
    .inv_size  (inv_size),
    .cnt       (cnt),
    .ghost     (ghost),
    .upper     (upper),
    .nx        (nx),
    .nxy       (nxy)
  );

  ctbi_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .pos_x    (pos_x),
    .pos_y    (pos_y),
    .pos_z    (pos_z),
    .box_lo   (box_lo),
    .box_hi   (box_hi),
    .fr_valid (fr_valid),
    .fr_ready (fr_ready),
    .fr_word  (fr_word)
  );

  ctbi_queue #(
    .WIDTH (WORD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fr_valid),
    .wr_ready (fr_ready),
    .wr_word  (fr_word),
    .rd_valid (bk_valid),
    .rd_ready (bk_ready),
    .rd_word  (bk_word)
  );

  ctbi_back #(
    .COORD_BITS (COORD_BITS),
    .BIN_BITS   (BIN_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .bk_valid    (bk_valid),
    .bk_ready    (bk_ready),
    .bk_word     (bk_word),
    .inv_size    (inv_size),
    .cnt         (cnt),
    .ghost       (ghost),
    .upper       (upper),
    .nx          (nx),
    .nxy         (nxy),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .bin_index   (bin_index),
    .cell_x      (cell_x),
    .cell_y      (cell_y),
    .cell_z      (cell_z),
    .out_of_grid (out_of_grid)
  );

endmodule
